// ===== hdl/range_min_tree_chmin_defines.svh =====
// assertion macros for the range minimum tree
`ifndef RANGE_MIN_TREE_CHMIN_DEFINES_SVH
`define RANGE_MIN_TREE_CHMIN_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge outside reset
`define RMT_CHECK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("range_min_tree_chmin: check failed");

// antecedent in one cycle, consequent in the next
`define RMT_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("range_min_tree_chmin: sequence check failed");

`else

`define RMT_CHECK(lbl, clk, rst, prop)
`define RMT_CHECK_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/rmt_pkg.sv =====
package rmt_pkg;

   // fixed field widths
   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int BND_W = 11;

   localparam int LEAVES_DEFAULT     = 1024;
   localparam int NODE_DEPTH_DEFAULT = 2 * LEAVES_DEFAULT;
   localparam int NODE_AW_DEFAULT    = $clog2(NODE_DEPTH_DEFAULT);

   // value of every position after reset, and of an empty query
   localparam logic signed [VAL_W-1:0] INIT_MIN = 32'sd1000000000;

   // request codes
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_UPD_MERGE,
      S_UPD_CLIMB,
      S_Q_LEFT,
      S_Q_RIGHT,
      S_DONE
   } state_type;

   function automatic logic signed [VAL_W-1:0] min_word(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== hdl/rmt_node_ram.sv =====
// node store: one write port, one read port, registered read data
module rmt_node_ram #(
   parameter int DEPTH = rmt_pkg::NODE_DEPTH_DEFAULT,
   parameter int AW    = rmt_pkg::NODE_AW_DEFAULT,
   parameter int DW    = rmt_pkg::VAL_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/range_min_tree_chmin.sv =====
// range minimum tree with point chmin updates, over LEAVES positions
// req channel (valid/stall): one word per request. req_type selects a point
//   update (position, value) or a range query [range_lo, range_hi)
// rsp channel (valid/stall): one word per request, rsp_min_value is the new
//   leaf value of an update or the minimum of the query range
// the tree is a flat array of 2*LEAVES nodes in one single-port-read,
//   single-port-write memory with registered read data; the sequencer walks it
// update: leaf read, merge, then a climb step per tree level reading the
//   sibling and writing the parent; a position outside the tree goes straight
//   to the done state
// query: a left and a right step per tree level, one for each bound, as each
//   may need a node read
// one request is in the tree at a time; the next is taken as soon as the
//   finished word has moved to the output register, even if it is stalled
// reset: a clearing pass writes 1000000000 to all 2*LEAVES nodes, one a
//   cycle, with req_stall high throughout
// a stalled rsp word holds; the sequencer waits in its done state until
//   the output register is free
`include "range_min_tree_chmin_defines.svh"

module range_min_tree_chmin #(
   parameter int LEAVES = rmt_pkg::LEAVES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [rmt_pkg::POS_W-1:0]        req_position,
   input  logic signed [rmt_pkg::VAL_W-1:0] req_value,
   input  logic [rmt_pkg::BND_W-1:0]        req_range_lo,
   input  logic [rmt_pkg::BND_W-1:0]        req_range_hi,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [rmt_pkg::VAL_W-1:0] rsp_min_value
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int NW    = $clog2(DEPTH);          // node address bits
   localparam int XW    = $clog2(DEPTH + 1);      // node counter, holds DEPTH
   localparam int CW    = (XW > rmt_pkg::BND_W) ? XW : rmt_pkg::BND_W;
   localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
   localparam logic [XW-1:0] LAST_NODE = XW'(DEPTH - 1);
   localparam logic [XW-1:0] ROOT      = XW'(1);

   rmt_pkg::state_type state_ff, state_in;

   logic [XW-1:0]                     node_ff, node_in;    // update index / query left
   logic [XW-1:0]                     right_ff, right_in;  // query right bound
   logic [XW-1:0]                     clr_ff, clr_in;
   logic signed [rmt_pkg::VAL_W-1:0]  val_ff, val_in;
   logic signed [rmt_pkg::VAL_W-1:0]  cur_ff, cur_in;      // value of node just written
   logic signed [rmt_pkg::VAL_W-1:0]  res_ff, res_in;
   logic                              pend_ff, pend_in;    // read data due this cycle
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [rmt_pkg::VAL_W-1:0]  rsp_min_value_ff, rsp_min_value_in;

   logic                              ram_we, ram_re;
   logic [NW-1:0]                     ram_waddr, ram_raddr;
   logic [rmt_pkg::VAL_W-1:0]         ram_wdata, ram_rdata;
   logic signed [rmt_pkg::VAL_W-1:0]  rd_word;

   logic [CW-1:0]                     pos_c, lo_c, hi_c, lo_cl, hi_cl;
   logic [CW-1:0]                     leaf_c, l_c, r_c;
   logic signed [rmt_pkg::VAL_W-1:0]  merged;
   logic [XW-1:0]                     parent;
   logic                              out_free;
   logic                              req_accept;

   rmt_node_ram #(
      .DEPTH (DEPTH),
      .AW    (NW),
      .DW    (rmt_pkg::VAL_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_word    = $signed(ram_rdata);
   assign req_stall  = (state_ff != rmt_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // request decode: leaf index and clamped query bounds in tree coordinates
   always_comb begin
      pos_c  = CW'(req_position);
      lo_c   = CW'(req_range_lo);
      hi_c   = CW'(req_range_hi);
      lo_cl  = (lo_c > LEAVES_C) ? LEAVES_C : lo_c;
      hi_cl  = (hi_c > LEAVES_C) ? LEAVES_C : hi_c;
      leaf_c = pos_c + LEAVES_C;
      l_c    = lo_cl + LEAVES_C;
      r_c    = hi_cl + LEAVES_C;
   end

   assign parent = node_ff >> 1;
   // fold in the node read issued last cycle, queries only
   assign merged = pend_ff ? rmt_pkg::min_word(res_ff, rd_word) : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmt_pkg::S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff          <= node_in;
      right_ff         <= right_in;
      val_ff           <= val_in;
      cur_ff           <= cur_in;
      res_ff           <= res_in;
      rsp_min_value_ff <= rsp_min_value_in;
   end

   always_comb begin
      state_in         = state_ff;
      node_in          = node_ff;
      right_in         = right_ff;
      clr_in           = clr_ff;
      val_in           = val_ff;
      cur_in           = cur_ff;
      res_in           = res_ff;
      pend_in          = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_min_value_in = rsp_min_value_ff;
      ram_we           = 1'b0;
      ram_waddr        = node_ff[NW-1:0];
      ram_wdata        = cur_ff;
      ram_re           = 1'b0;
      ram_raddr        = node_ff[NW-1:0];

      case (state_ff)
         rmt_pkg::S_CLEAR: begin
            // clearing pass, one node a cycle
            ram_we    = 1'b1;
            ram_waddr = clr_ff[NW-1:0];
            ram_wdata = rmt_pkg::INIT_MIN;
            clr_in    = clr_ff + XW'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = rmt_pkg::S_IDLE;
            end
         end

         rmt_pkg::S_IDLE: begin
            if (req_accept) begin
               res_in = rmt_pkg::INIT_MIN;
               if (req_type == rmt_pkg::REQ_UPDATE) begin
                  val_in = req_value;
                  if (pos_c < LEAVES_C) begin
                     // fetch the old leaf word
                     node_in   = leaf_c[XW-1:0];
                     ram_re    = 1'b1;
                     ram_raddr = leaf_c[NW-1:0];
                     state_in  = rmt_pkg::S_UPD_MERGE;
                  end else begin
                     state_in = rmt_pkg::S_DONE;
                  end
               end else begin
                  node_in  = l_c[XW-1:0];
                  right_in = r_c[XW-1:0];
                  state_in = rmt_pkg::S_Q_LEFT;
               end
            end
         end

         rmt_pkg::S_UPD_MERGE: begin
            // lower the leaf, write it back, fetch its sibling
            cur_in    = rmt_pkg::min_word(rd_word, val_ff);
            res_in    = rmt_pkg::min_word(rd_word, val_ff);
            ram_we    = 1'b1;
            ram_waddr = node_ff[NW-1:0];
            ram_wdata = rmt_pkg::min_word(rd_word, val_ff);
            ram_re    = 1'b1;
            ram_raddr = node_ff[NW-1:0] ^ NW'(1);
            state_in  = rmt_pkg::S_UPD_CLIMB;
         end

         rmt_pkg::S_UPD_CLIMB: begin
            // sibling word is here: write the parent, fetch the parent's sibling unless the parent is the root
            cur_in    = rmt_pkg::min_word(cur_ff, rd_word);
            ram_we    = 1'b1;
            ram_waddr = parent[NW-1:0];
            ram_wdata = rmt_pkg::min_word(cur_ff, rd_word);
            node_in   = parent;
            if (parent == ROOT) begin
               state_in = rmt_pkg::S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = parent[NW-1:0] ^ NW'(1);
            end
         end

         rmt_pkg::S_Q_LEFT: begin
            res_in = merged;
            if (node_ff >= right_ff) begin
               state_in = rmt_pkg::S_DONE;
            end else begin
               if (node_ff[0]) begin
                  ram_re    = 1'b1;
                  ram_raddr = node_ff[NW-1:0];
                  pend_in   = 1'b1;
                  node_in   = node_ff + XW'(1);
               end
               state_in = rmt_pkg::S_Q_RIGHT;
            end
         end

         rmt_pkg::S_Q_RIGHT: begin
            res_in = merged;
            if (right_ff[0]) begin
               ram_re    = 1'b1;
               ram_raddr = right_ff[NW-1:0] - NW'(1);
               pend_in   = 1'b1;
            end
            // odd right bound: (r - 1) >> 1 equals r >> 1
            node_in  = node_ff >> 1;
            right_in = right_ff >> 1;
            state_in = rmt_pkg::S_Q_LEFT;
         end

         rmt_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_min_value_in = res_ff;
               state_in         = rmt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rmt_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;

   // a write never lands on the node being read in the same cycle
   `RMT_CHECK(a_no_rw_same_node, clock, reset, !(ram_we && ram_re) || (ram_waddr != ram_raddr))
   // the climb never reaches past the root
   `RMT_CHECK(a_climb_below_root, clock, reset, (state_ff != rmt_pkg::S_UPD_CLIMB) || (node_ff > ROOT))
   // an accepted word always starts the sequencer
   `RMT_CHECK_NEXT(a_accept_starts, clock, reset, req_accept, state_ff != rmt_pkg::S_IDLE)
   // a finished word reaches the output register when it is free
   `RMT_CHECK_NEXT(a_done_delivers, clock, reset, (state_ff == rmt_pkg::S_DONE) && out_free, rsp_valid_ff && (rsp_min_value_ff == $past(res_ff)))

endmodule

// ===== sim/range_min_tree_chmin_chk.sv =====
module range_min_tree_chmin_chk (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_type,
   input  logic [rmt_pkg::POS_W-1:0]        req_position,
   input  logic signed [rmt_pkg::VAL_W-1:0] req_value,
   input  logic [rmt_pkg::BND_W-1:0]        req_range_lo,
   input  logic [rmt_pkg::BND_W-1:0]        req_range_hi,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [rmt_pkg::VAL_W-1:0] rsp_min_value,
   output int                               fail_count,
   output int                               pending,
   output int                               update_count,
   output int                               query_count,
   output int                               compared_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W  = rmt_pkg::POS_W;
   localparam int VAL_W  = rmt_pkg::VAL_W;
   localparam int BND_W  = rmt_pkg::BND_W;
   localparam int LEAVES = rmt_pkg::LEAVES_DEFAULT;

   // own copy of the tree, node k holds the minimum of nodes 2k and 2k+1
   logic signed [VAL_W-1:0] tree_min [1:2*LEAVES-1];
   logic signed [VAL_W-1:0] expected_min [$];
   logic signed [VAL_W-1:0] want;
   int errors;
   int updates;
   int queries;
   int results;

   initial begin
      errors = 0;
      updates = 0;
      queries = 0;
      results = 0;
      fail_count = 0;
      pending = 0;
      update_count = 0;
      query_count = 0;
      compared_count = 0;
   end

   // chmin on one leaf, then refresh every ancestor; returns the new leaf
   function automatic logic signed [VAL_W-1:0] lower_leaf(
      input logic [POS_W-1:0]        pos,
      input logic signed [VAL_W-1:0] val
   );
      int unsigned k;
      logic signed [VAL_W-1:0] leaf;
      if (pos >= LEAVES) return rmt_pkg::INIT_MIN;
      k = LEAVES + pos;
      if (val < tree_min[k]) tree_min[k] = val;
      leaf = tree_min[k];
      k = k >> 1;
      while (k >= 1) begin
         tree_min[k] = (tree_min[2*k] < tree_min[2*k+1]) ? tree_min[2*k] : tree_min[2*k+1];
         k = k >> 1;
      end
      return leaf;
   endfunction

   // minimum over [lo, hi) with both bounds clamped to the tree
   function automatic logic signed [VAL_W-1:0] span_minimum(
      input logic [BND_W-1:0] lo,
      input logic [BND_W-1:0] hi
   );
      int unsigned l;
      int unsigned r;
      logic signed [VAL_W-1:0] best;
      l = lo;
      r = hi;
      best = rmt_pkg::INIT_MIN;
      if (l > LEAVES) l = LEAVES;
      if (r > LEAVES) r = LEAVES;
      if (l >= r) return rmt_pkg::INIT_MIN;
      l = l + LEAVES;
      r = r + LEAVES;
      while (l < r) begin
         if (l % 2 == 1) begin
            if (tree_min[l] < best) best = tree_min[l];
            l = l + 1;
         end
         if (r % 2 == 1) begin
            r = r - 1;
            if (tree_min[r] < best) best = tree_min[r];
         end
         l = l >> 1;
         r = r >> 1;
      end
      return best;
   endfunction

   task automatic note_failure(input string what);
      errors++;
      if (errors <= 10) $display("[%0t] rsp word %0d: %s", $realtime, results, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k < 2*LEAVES; k++) tree_min[k] = rmt_pkg::INIT_MIN;
         expected_min.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_min.size() == 0) begin
               note_failure($sformatf("unexpected word, min_value %0d", rsp_min_value));
            end else begin
               want = expected_min.pop_front();
               results++;
               if (rsp_min_value !== want)
                  note_failure($sformatf("min_value expected %0d actual %0d",
                                         want, rsp_min_value));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == rmt_pkg::REQ_QUERY) begin
               queries++;
               expected_min.insert(expected_min.size(),
                                   span_minimum(req_range_lo, req_range_hi));
            end else begin
               updates++;
               expected_min.insert(expected_min.size(),
                                   lower_leaf(req_position, req_value));
            end
         end
      end
      fail_count     <= errors;
      pending        <= expected_min.size();
      update_count   <= updates;
      query_count    <= queries;
      compared_count <= results;
   end

endmodule

// ===== sim/range_min_tree_chmin_tb.sv =====
module range_min_tree_chmin_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W = rmt_pkg::POS_W;
   localparam int VAL_W = rmt_pkg::VAL_W;
   localparam int BND_W = rmt_pkg::BND_W;

   // covers the clearing pass over all 2*LEAVES nodes and every item, plus stalls
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_WORDS = 500;
   localparam int DRAIN_CYCLES = 40;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = rmt_pkg::REQ_UPDATE;
   logic [POS_W-1:0] req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [BND_W-1:0] req_range_lo = '0;
   logic [BND_W-1:0] req_range_hi = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_min_value;

   int fail_count;
   int pending;
   int update_count;
   int query_count;
   int compared_count;
   int cycles = 0;

   // while set, neither side idles
   logic calm = 1'b0;

   range_min_tree_chmin #(.LEAVES(rmt_pkg::LEAVES_DEFAULT)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_position  (req_position),
      .req_value     (req_value),
      .req_range_lo  (req_range_lo),
      .req_range_hi  (req_range_hi),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_min_value (rsp_min_value)
   );

   range_min_tree_chmin_chk chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_range_lo   (req_range_lo),
      .req_range_hi   (req_range_hi),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_min_value  (rsp_min_value),
      .fail_count     (fail_count),
      .pending        (pending),
      .update_count   (update_count),
      .query_count    (query_count),
      .compared_count (compared_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, about one cycle in five
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
         $display("FAIL range_min_tree_chmin");
         $finish;
      end
   end

   // offer one word and hold it until taken; called just after a rising edge
   task automatic send_word(
      input logic                    kind,
      input logic [POS_W-1:0]        pos,
      input logic signed [VAL_W-1:0] val,
      input logic [BND_W-1:0]        lo,
      input logic [BND_W-1:0]        hi
   );
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(0, 99) < 21) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_value    <= val;
      req_range_lo <= lo;
      req_range_hi <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic update_word(input int pos, input logic signed [VAL_W-1:0] val);
      send_word(rmt_pkg::REQ_UPDATE, POS_W'(pos), val,
                BND_W'($urandom_range(0, 2047)), BND_W'($urandom_range(0, 2047)));
   endtask

   task automatic query_word(input int lo, input int hi);
      send_word(rmt_pkg::REQ_QUERY, POS_W'($urandom), $urandom, BND_W'(lo), BND_W'(hi));
   endtask

   initial begin
      int lo;
      int hi;
      int pos;
      logic signed [VAL_W-1:0] val;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part: untouched tree, field extremes, clamping, empty ranges
      query_word(0, 1024);                  // whole tree before any update
      update_word(0, VAL_MIN);              // most negative into first leaf
      update_word(1023, VAL_MAX);           // larger than stored, leaf keeps its value
      update_word(1023, rmt_pkg::INIT_MIN - 1); // last leaf just below the start value
      send_word(rmt_pkg::REQ_UPDATE, 10'd512, '0, 11'h7ff, 11'h7ff); // bounds ignored
      query_word(0, 1024);
      query_word(1, 1024);
      query_word(1023, 1024);               // single last leaf
      query_word(1024, 1024);               // empty at the top edge
      query_word(2047, 2047);               // both bounds beyond the tree
      query_word(1000, 2047);               // upper bound clamped
      query_word(2047, 0);                  // reversed across the whole width
      query_word(5, 3);                     // reversed
      query_word(7, 7);                     // empty
      send_word(rmt_pkg::REQ_QUERY, 10'h3ff, -32'sd1, 11'd0, 11'd1); // position, value ignored
      update_word(1, rmt_pkg::INIT_MIN);    // equal to stored
      update_word(1, rmt_pkg::INIT_MIN + 1); // above stored
      update_word(1, -32'sd1);
      query_word(1, 2);
      update_word(0, VAL_MAX);
      query_word(0, 2);

      // random part, with a quiet stretch in the middle
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 150 && i < 300);
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0, 1: pos = $urandom_range(0, 15);     // hot corner, repeated chmin
               2: pos = $urandom_range(1008, 1023);
               default: pos = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 3))
               0: val = $urandom;
               1: val = $signed($urandom_range(0, 2000)) - 1000;
               2: val = rmt_pkg::INIT_MIN - $signed($urandom_range(0, 1000));
               default: val = rmt_pkg::INIT_MIN - $signed($urandom_range(0, 5000000));
            endcase
            update_word(pos, val);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  lo = $urandom_range(0, 1023);
                  hi = lo + 1 + $urandom_range(0, 1023 - lo);
               end
               6, 7: begin
                  lo = $urandom_range(0, 30);
                  hi = lo + $urandom_range(0, 8);
               end
               8: begin
                  lo = $urandom_range(0, 2047);
                  hi = $urandom_range(0, 2047);
               end
               default: begin
                  hi = $urandom_range(0, 1024);
                  lo = hi + $urandom_range(0, 20);
               end
            endcase
            query_word(lo, hi);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // one edge so the owed count includes the last word, then drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d point updates and %0d range queries, %0d words compared",
               update_count, query_count, compared_count);
      $display("including clamped, empty and reversed ranges and both value extremes");
      if (fail_count == 0 && pending == 0) begin
         $display("PASS range_min_tree_chmin");
      end else begin
         $display("%0d failures", fail_count);
         $display("FAIL range_min_tree_chmin");
      end
      $finish;
   end

endmodule
